// ===== src/vcrq_pkg.sv =====
`timescale 1ns / 1ps

package vcrq_pkg;

	localparam int CMD_IN_W   = 8;
	localparam int LEN_IN_W   = 8;
	localparam int CMD_W      = 3;
	localparam int LEN_W      = 3;
	localparam int PAY_BYTES  = 6;
	localparam int PAY_W      = 8 * PAY_BYTES;
	localparam int CMD_COUNT  = 8;
	localparam int MASK_W     = 8;
	localparam int TABLE_W    = 24;
	localparam int CFG_W      = 24;
	localparam int CFG_IDX_W  = 1;
	localparam int OCC_W      = 6;

	localparam logic [1:0] OP_POST     = 2'd0;
	localparam logic [1:0] OP_DISPATCH = 2'd1;
	localparam logic [1:0] OP_CLEAR    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_TABLE = 1'd1;

	typedef enum logic [2:0] {
		STAT_POSTED    = 3'd0,
		STAT_INVALID   = 3'd1,
		STAT_FULL      = 3'd2,
		STAT_DELIVERED = 3'd3,
		STAT_EMPTY     = 3'd4,
		STAT_DROPPED   = 3'd5,
		STAT_CLEARED   = 3'd6
	} status_t;

	typedef struct packed {
		logic [1:0]          operation;
		logic [CMD_IN_W-1:0] command;
		logic [LEN_IN_W-1:0] length;
		logic [PAY_W-1:0]    payload;
	} item_t;

	typedef struct packed {
		status_t          status;
		logic [CMD_W-1:0] out_command;
		logic [LEN_W-1:0] out_length;
		logic [PAY_W-1:0] out_payload;
		logic [OCC_W-1:0] occupancy;
	} result_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [LEN_W-1:0] len;
		logic [PAY_W-1:0] data;
	} entry_t;

	// Decision made at acceptance; a pop is resolved once the ring data is back.
	typedef struct packed {
		status_t          status;
		logic             pop;
		logic [OCC_W-1:0] occupancy;
	} ctrl_t;

endpackage

// ===== src/vcrq_ring_ram.sv =====
`timescale 1ns / 1ps

module vcrq_ring_ram
	import vcrq_pkg::*;
#(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_entry,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_entry
);

	entry_t mem_q [DEPTH];
	entry_t rd_entry_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_entry_q <= mem_q[rd_addr];
		end
	end

	assign rd_entry = rd_entry_q;

endmodule

// ===== src/vcrq_ctrl.sv =====
`timescale 1ns / 1ps

module vcrq_ctrl
	import vcrq_pkg::*;
#(
	parameter int DEPTH = 32,
	parameter int AW    = 5,
	parameter int CNT_W = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  item_t             item,
	input  logic [MASK_W-1:0] enable_mask,
	input  logic [TABLE_W-1:0] length_table,
	output logic              wr_en,
	output logic [AW-1:0]     wr_addr,
	output entry_t            wr_entry,
	output logic              rd_en,
	output logic [AW-1:0]     rd_addr,
	output logic              valid_s1,
	output ctrl_t             ctrl_s1
);

	logic [AW-1:0]    wr_ptr_q, rd_ptr_q, wr_ptr_d, rd_ptr_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             cmd_ok, len_ok, full, empty, has_result;
	logic [CMD_W-1:0] cmd_idx;
	logic [LEN_W-1:0] req_len;
	logic [PAY_W-1:0] masked_pay;
	ctrl_t            ctrl_d;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign cmd_idx = item.command[CMD_W-1:0];
	assign req_len = length_table[cmd_idx * LEN_W +: LEN_W];
	assign cmd_ok  = (item.command < CMD_IN_W'(CMD_COUNT)) && enable_mask[cmd_idx];
	assign len_ok  = (item.length == {{(LEN_IN_W - LEN_W){1'b0}}, req_len})
		&& (item.length <= LEN_IN_W'(PAY_BYTES));
	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);

	// Bytes at or past the claimed length are stored as zero.
	always_comb begin
		for (int b = 0; b < PAY_BYTES; b++) begin
			masked_pay[b*8 +: 8] = (item.length > LEN_IN_W'(b)) ? item.payload[b*8 +: 8] : 8'h00;
		end
	end

	always_comb begin
		wr_ptr_d   = wr_ptr_q;
		rd_ptr_d   = rd_ptr_q;
		count_d    = count_q;
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		has_result = 1'b0;
		ctrl_d.status = STAT_CLEARED;
		ctrl_d.pop    = 1'b0;
		case (item.operation)
			OP_POST: begin
				has_result = 1'b1;
				if (!(cmd_ok && len_ok)) begin
					ctrl_d.status = STAT_INVALID;
				end else if (full) begin
					ctrl_d.status = STAT_FULL;
				end else begin
					ctrl_d.status = STAT_POSTED;
					wr_en    = accept;
					wr_ptr_d = wrap_inc(wr_ptr_q);
					count_d  = count_q + CNT_W'(1);
				end
			end
			OP_DISPATCH: begin
				has_result = 1'b1;
				if (empty) begin
					ctrl_d.status = STAT_EMPTY;
				end else begin
					ctrl_d.status = STAT_DELIVERED;
					ctrl_d.pop    = 1'b1;
					rd_en    = accept;
					rd_ptr_d = wrap_inc(rd_ptr_q);
					count_d  = count_q - CNT_W'(1);
				end
			end
			OP_CLEAR: begin
				has_result = 1'b1;
				ctrl_d.status = STAT_CLEARED;
				wr_ptr_d = '0;
				rd_ptr_d = '0;
				count_d  = '0;
			end
			default: begin
				has_result = 1'b0;
			end
		endcase
		ctrl_d.occupancy = OCC_W'(count_d);
	end

	assign wr_addr        = wr_ptr_q;
	assign rd_addr        = rd_ptr_q;
	assign wr_entry.cmd   = cmd_idx;
	assign wr_entry.len   = req_len;
	assign wr_entry.data  = masked_pay;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && has_result;
			if (accept) begin
				wr_ptr_q <= wr_ptr_d;
				rd_ptr_q <= rd_ptr_d;
				count_q  <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_s1 <= ctrl_d;
		end
	end

endmodule

// ===== src/validated_command_ring_queue.sv =====
`timescale 1ns / 1ps

// Channel   Handshake           Payload        Transfer when
// item      start / busy        item_t         start high, busy low
// result    done (strobe)       result_t       done high, one cycle only
// config    cfg_we              cfg_index/data cfg_we high
//
// One item is taken every cycle; busy stays low. Its result passes through the registered
// read port of the ring memory, alongside the control register, and then through the
// result register. Reset zeroes the pointers, the entry count and both configuration
// registers; the ring contents are never cleared, since the count only covers written entries.
// The receiver cannot stall; each result is shown for exactly one cycle.
// QUEUE_DEPTH may range from 2 to 63 so that the occupancy field can hold it.

module validated_command_ring_queue
	import vcrq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  item_t                item,
	output logic                 done,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [MASK_W-1:0]  enable_mask_q;
	logic [TABLE_W-1:0] length_table_q;
	logic               accept, wr_en, rd_en, valid_s1, entry_on;
	logic [AW-1:0]      wr_addr, rd_addr;
	entry_t             wr_entry, rd_entry;
	ctrl_t              ctrl_s1;
	result_t            result_d;
	logic               done_q;
	result_t            result_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_mask_q  <= '0;
			length_table_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENABLE_MASK:  enable_mask_q  <= cfg_data[MASK_W-1:0];
				CFG_LENGTH_TABLE: length_table_q <= cfg_data[TABLE_W-1:0];
				default: ;
			endcase
		end
	end

	vcrq_ctrl #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW),
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.item         (item),
		.enable_mask  (enable_mask_q),
		.length_table (length_table_q),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_entry     (wr_entry),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.valid_s1     (valid_s1),
		.ctrl_s1      (ctrl_s1)
	);

	vcrq_ring_ram #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_entry (wr_entry),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry)
	);

	// A popped entry is delivered only if its command is still enabled now.
	assign entry_on = enable_mask_q[rd_entry.cmd];

	always_comb begin
		result_d.status      = ctrl_s1.status;
		result_d.out_command = '0;
		result_d.out_length  = '0;
		result_d.out_payload = '0;
		result_d.occupancy   = ctrl_s1.occupancy;
		if (ctrl_s1.pop) begin
			result_d.out_command = rd_entry.cmd;
			if (entry_on) begin
				result_d.status      = STAT_DELIVERED;
				result_d.out_length  = rd_entry.len;
				result_d.out_payload = rd_entry.data;
			end else begin
				result_d.status = STAT_DROPPED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.operation == OP_CLEAR |-> ##2
		(done && result.status == STAT_CLEARED && result.occupancy == '0))
		else $error("clear did not report an empty queue");

	a_occupancy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.occupancy <= OCC_W'(QUEUE_DEPTH))
		else $error("occupancy beyond queue depth");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == STAT_EMPTY |-> result.occupancy == '0)
		else $error("empty dispatch with entries held");

	a_drop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == STAT_DROPPED |-> result.out_length == '0
		&& result.out_payload == '0)
		else $error("dropped entry carries payload");

endmodule
